/* hw/rtl/skpc_pkg.sv */
// ----------------------------------------------------------------------------
// skpc_pkg
// Shared types, constants and helpers of the soft-knee peak compressor.
// ----------------------------------------------------------------------------
package skpc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd5;

  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
  localparam logic [31:0] LOG2_PER_DB_Q24 = 32'd2786635;
  localparam logic [31:0] RECIP_12_Q26    = 32'd5592406;
  localparam int          KNEE_HALF_Q16   = 196608;
  localparam logic [22:0] FLOOR_DB_Q16    = 23'd7864320;
  localparam logic [17:0] P_C1            = 18'd45594;
  localparam logic [17:0] P_C2            = 18'd14824;
  localparam logic [17:0] P_C3            = 18'd5118;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic        [22:0]            reduction_db;
  } out_t;

  typedef struct packed {
    logic signed [9:0] threshold_tenth_db;
    logic [15:0]       knee_slope;
    logic [23:0]       attack_coef;
    logic [23:0]       release_coef;
    logic [7:0]        makeup_tenth_db;
    logic              comp_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_SQUARE, OP_LEVEL, OP_KNEE_A, OP_KNEE_B, OP_KNEE_C,
    OP_ENV_A, OP_ENV_B, OP_LOG2, OP_POLY_A, OP_POLY_B, OP_POLY_C,
    OP_SCALE_L, OP_SCALE_R, OP_EMIT
  } op_t;

  typedef struct packed {
    logic knee;
    logic out_free;
  } status_t;

  // (mag * 65536 + 5) / 10, split so that only a short remainder is divided.
  function automatic logic [21:0] tenths_to_q16(input logic [9:0] mag);
    logic [21:0] whole;
    logic [11:0] y;
    logic [24:0] yq;
    whole = 22'(32'(mag) * 32'd6553);
    y     = 12'(16'(mag) * 16'd6 + 16'd5);
    yq    = 25'(y) * 25'd6554;
    return whole + 22'(yq >> 16);
  endfunction

endpackage

/* hw/rtl/skpc_cfg.sv */
// ----------------------------------------------------------------------------
// skpc_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module skpc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [skpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output skpc_pkg::cfg_t                     cfg
);

  skpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_tenth_db <= -10'sd180;
      cfg_r.knee_slope         <= 16'd49152;
      cfg_r.attack_coef        <= 24'd16742300;
      cfg_r.release_coef       <= 24'd16773721;
      cfg_r.makeup_tenth_db    <= 8'd30;
      cfg_r.comp_enable        <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skpc_pkg::CFG_THRESHOLD: cfg_r.threshold_tenth_db <= $signed(cfg_wdata[9:0]);
        skpc_pkg::CFG_SLOPE:     cfg_r.knee_slope         <= cfg_wdata[15:0];
        skpc_pkg::CFG_ATTACK:    cfg_r.attack_coef        <= cfg_wdata[23:0];
        skpc_pkg::CFG_RELEASE:   cfg_r.release_coef       <= cfg_wdata[23:0];
        skpc_pkg::CFG_MAKEUP:    cfg_r.makeup_tenth_db    <= cfg_wdata[7:0];
        skpc_pkg::CFG_ENABLE:    cfg_r.comp_enable        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/skpc_ctrl.sv */
// ----------------------------------------------------------------------------
// skpc_ctrl
// Sequencer that steps the datapath through one sample pair.
// ----------------------------------------------------------------------------
module skpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skpc_pkg::status_t   status,
  output skpc_pkg::op_t       op
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_LEVEL, ST_KNEE_A, ST_KNEE_B, ST_KNEE_C, ST_ENV_A,
    ST_ENV_B, ST_LOG2, ST_POLY_A, ST_POLY_B, ST_POLY_C, ST_SCALE_L,
    ST_SCALE_R, ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  sq_cnt_r, sq_cnt_nxt;

  always_comb begin
    state_nxt  = state_r;
    sq_cnt_nxt = sq_cnt_r;
    op         = skpc_pkg::OP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op         = skpc_pkg::OP_LOAD;
          sq_cnt_nxt = '0;
          state_nxt  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        op         = skpc_pkg::OP_SQUARE;
        sq_cnt_nxt = sq_cnt_r + 4'd1;
        if (sq_cnt_r == 4'hF) state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        op        = skpc_pkg::OP_LEVEL;
        state_nxt = ST_KNEE_A;
      end
      ST_KNEE_A: begin
        op        = skpc_pkg::OP_KNEE_A;
        state_nxt = status.knee ? ST_KNEE_B : ST_ENV_A;
      end
      ST_KNEE_B: begin
        op        = skpc_pkg::OP_KNEE_B;
        state_nxt = ST_KNEE_C;
      end
      ST_KNEE_C: begin
        op        = skpc_pkg::OP_KNEE_C;
        state_nxt = ST_ENV_A;
      end
      ST_ENV_A: begin
        op        = skpc_pkg::OP_ENV_A;
        state_nxt = ST_ENV_B;
      end
      ST_ENV_B: begin
        op        = skpc_pkg::OP_ENV_B;
        state_nxt = ST_LOG2;
      end
      ST_LOG2: begin
        op        = skpc_pkg::OP_LOG2;
        state_nxt = ST_POLY_A;
      end
      ST_POLY_A: begin
        op        = skpc_pkg::OP_POLY_A;
        state_nxt = ST_POLY_B;
      end
      ST_POLY_B: begin
        op        = skpc_pkg::OP_POLY_B;
        state_nxt = ST_POLY_C;
      end
      ST_POLY_C: begin
        op        = skpc_pkg::OP_POLY_C;
        state_nxt = ST_SCALE_L;
      end
      ST_SCALE_L: begin
        op        = skpc_pkg::OP_SCALE_L;
        state_nxt = ST_SCALE_R;
      end
      ST_SCALE_R: begin
        op        = skpc_pkg::OP_SCALE_R;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        op = skpc_pkg::OP_EMIT;
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      sq_cnt_r <= sq_cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

/* hw/rtl/skpc_dp.sv */
// ----------------------------------------------------------------------------
// skpc_dp
// Datapath: level detector, gain computer, envelope and gain stage around
// one shared multiplier, plus the output register.
// ----------------------------------------------------------------------------
module skpc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  skpc_pkg::op_t       op,
  input  skpc_pkg::cfg_t      cfg,
  input  skpc_pkg::in_t       in_data,
  input  logic                out_ready,
  output skpc_pkg::status_t   status,
  output logic                out_valid,
  output skpc_pkg::out_t      out_data
);

  localparam int SB  = skpc_pkg::SAMPLE_BITS;
  localparam int E_W = $clog2(SB);

  logic signed [SB-1:0] l_r, r_r, ol_r, or_r;
  logic [E_W-1:0]       e_r;
  logic                 zero_r;
  logic [31:0]          m_r;
  logic [15:0]          frac_r;
  logic [22:0]          level_mag_r;
  logic [34:0]          t1_r;
  logic [18:0]          x_r;
  logic [21:0]          y_r;
  logic [23:0]          target_r;
  logic [23:0]          env_r;
  logic [47:0]          acc_r;
  logic signed [6:0]    n_r;
  logic [15:0]          f_r;
  logic [17:0]          p_r;
  logic                 out_valid_r;
  skpc_pkg::out_t       out_r;

  // Shared multiplier.
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [67:0] prod;
  assign prod = 68'(mul_a) * 68'(mul_b);

  // Peak detection on the incoming pair.
  logic [SB-1:0]  abs_l, abs_r, peak;
  logic [E_W-1:0] msb;
  logic [31:0]    m0;

  assign abs_l = in_data.left_in[SB-1]  ? SB'(-in_data.left_in)  : SB'(in_data.left_in);
  assign abs_r = in_data.right_in[SB-1] ? SB'(-in_data.right_in) : SB'(in_data.right_in);
  assign peak  = (abs_l > abs_r) ? abs_l : abs_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < SB; i++) begin
      if (peak[i]) msb = E_W'(i);
    end
  end
  assign m0 = 32'(peak) << (6'd30 - 6'(msb));

  // One squaring round of the log2 fraction.
  logic [31:0] mm;
  assign mm = prod[61:30];

  // Level in dB.
  logic [21:0] neg;
  logic [47:0] lvl_sum;
  logic [22:0] lvl_mag;
  assign neg     = 22'((SB - 1) << 16) - 22'({e_r, frac_r});
  assign lvl_sum = prod[47:0] + 48'd32768;
  always_comb begin
    if (zero_r || lvl_sum[47:16] > 32'(skpc_pkg::FLOOR_DB_Q16)) lvl_mag = skpc_pkg::FLOOR_DB_Q16;
    else lvl_mag = lvl_sum[38:16];
  end

  // Overshoot above threshold and knee region.
  logic [9:0]         thr_abs;
  logic [21:0]        thr_mag;
  logic signed [25:0] thr_q16, over;
  logic               below, above;
  logic [18:0]        x_knee;
  assign thr_abs = cfg.threshold_tenth_db[9] ? 10'(-cfg.threshold_tenth_db)
                                             : 10'(cfg.threshold_tenth_db);
  assign thr_mag = skpc_pkg::tenths_to_q16(thr_abs);
  assign thr_q16 = cfg.threshold_tenth_db[9] ? -$signed({4'b0, thr_mag})
                                             : $signed({4'b0, thr_mag});
  assign over    = -$signed({3'b0, level_mag_r}) - thr_q16;
  assign below   = over <= -26'sd196608;
  assign above   = over >= 26'sd196608;
  assign x_knee  = 19'(over + 26'sd196608);

  // Envelope.
  logic [23:0] coef;
  logic [24:0] coef_c;
  logic [48:0] env_sum;
  assign coef    = (target_r > env_r) ? cfg.attack_coef : cfg.release_coef;
  assign coef_c  = 25'(1 << 24) - 25'(coef);
  assign env_sum = 49'(acc_r) + prod[48:0] + 49'(1 << 23);

  // Gain in log2 domain.
  logic [21:0]        mk_q16;
  logic signed [25:0] dlt;
  logic [24:0]        dm;
  logic [47:0]        l2_sum;
  logic signed [22:0] l2;
  assign mk_q16 = skpc_pkg::tenths_to_q16({2'b0, cfg.makeup_tenth_db});
  assign dlt    = $signed({4'b0, mk_q16}) - $signed({2'b0, env_r});
  assign dm     = dlt[25] ? 25'(-dlt) : 25'(dlt);
  assign l2_sum = prod[47:0] + 48'(1 << 23);
  assign l2     = dlt[25] ? -$signed({1'b0, l2_sum[45:24]}) : $signed({1'b0, l2_sum[45:24]});

  // Gain stage for the sample selected by the current step.
  logic signed [SB-1:0] smp, scaled;
  logic [SB-1:0]        smp_abs, lim;
  logic signed [7:0]    shf;
  logic [5:0]           shf_sat;
  logic [63:0]          rnd;
  logic [SB-1:0]        mag_out;
  assign smp     = (op == skpc_pkg::OP_SCALE_R) ? r_r : l_r;
  assign smp_abs = smp[SB-1] ? SB'(-smp) : SB'(smp);
  assign lim     = smp[SB-1] ? SB'(1) << (SB - 1) : (SB'(1) << (SB - 1)) - SB'(1);
  assign shf     = 8'sd16 - 8'(n_r);
  always_comb begin
    if (shf < 8'sd1) shf_sat = 6'd1;
    else if (shf > 8'sd63) shf_sat = 6'd63;
    else shf_sat = shf[5:0];
  end
  assign rnd = (prod[63:0] + (64'd1 << (shf_sat - 6'd1))) >> shf_sat;
  assign mag_out = (rnd > 64'(lim)) ? lim : rnd[SB-1:0];
  assign scaled  = smp[SB-1] ? -$signed(mag_out) : $signed(mag_out);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      skpc_pkg::OP_SQUARE: begin
        mul_a = 36'(m_r);
        mul_b = m_r;
      end
      skpc_pkg::OP_LEVEL: begin
        mul_a = 36'(neg);
        mul_b = skpc_pkg::DB_PER_LOG2_Q16;
      end
      skpc_pkg::OP_KNEE_A: begin
        if (above) begin
          mul_a = 36'(over[21:0]);
          mul_b = 32'(cfg.knee_slope);
        end else begin
          mul_a = 36'(cfg.knee_slope);
          mul_b = 32'(x_knee);
        end
      end
      skpc_pkg::OP_KNEE_B: begin
        mul_a = 36'(t1_r);
        mul_b = 32'(x_r);
      end
      skpc_pkg::OP_KNEE_C: begin
        mul_a = 36'(y_r);
        mul_b = skpc_pkg::RECIP_12_Q26;
      end
      skpc_pkg::OP_ENV_A: begin
        mul_a = 36'(coef);
        mul_b = 32'(env_r);
      end
      skpc_pkg::OP_ENV_B: begin
        mul_a = 36'(coef_c);
        mul_b = 32'(target_r);
      end
      skpc_pkg::OP_LOG2: begin
        mul_a = 36'(dm);
        mul_b = skpc_pkg::LOG2_PER_DB_Q24;
      end
      skpc_pkg::OP_POLY_A: begin
        mul_a = 36'(skpc_pkg::P_C3);
        mul_b = 32'(f_r);
      end
      skpc_pkg::OP_POLY_B: begin
        mul_a = 36'(p_r + skpc_pkg::P_C2);
        mul_b = 32'(f_r);
      end
      skpc_pkg::OP_POLY_C: begin
        mul_a = 36'(p_r + skpc_pkg::P_C1);
        mul_b = 32'(f_r);
      end
      skpc_pkg::OP_SCALE_L, skpc_pkg::OP_SCALE_R: begin
        mul_a = 36'(smp_abs);
        mul_b = 32'(p_r);
      end
      default: ;
    endcase
  end

  assign status.knee     = !below && !above;
  assign status.out_free = !out_valid_r || out_ready;

  // Payload and working registers.
  always_ff @(posedge clk) begin
    unique case (op)
      skpc_pkg::OP_LOAD: begin
        l_r    <= in_data.left_in;
        r_r    <= in_data.right_in;
        e_r    <= msb;
        zero_r <= (peak == '0);
        m_r    <= m0;
        frac_r <= '0;
      end
      skpc_pkg::OP_SQUARE: begin
        m_r    <= mm[31] ? (mm >> 1) : mm;
        frac_r <= {frac_r[14:0], mm[31]};
      end
      skpc_pkg::OP_LEVEL: level_mag_r <= lvl_mag;
      skpc_pkg::OP_KNEE_A: begin
        if (below) target_r <= '0;
        else if (above) target_r <= prod[39:16];
        else begin
          t1_r <= prod[34:0];
          x_r  <= x_knee;
        end
      end
      skpc_pkg::OP_KNEE_B: y_r <= prod[53:32];
      skpc_pkg::OP_KNEE_C: target_r <= prod[49:26];
      skpc_pkg::OP_ENV_A:  acc_r <= prod[47:0];
      skpc_pkg::OP_LOG2: begin
        n_r <= l2[22:16];
        f_r <= l2[15:0];
      end
      skpc_pkg::OP_POLY_A, skpc_pkg::OP_POLY_B: p_r <= prod[33:16];
      skpc_pkg::OP_POLY_C: p_r <= prod[33:16] + 18'd65536;
      skpc_pkg::OP_SCALE_L: ol_r <= scaled;
      skpc_pkg::OP_SCALE_R: or_r <= scaled;
      skpc_pkg::OP_EMIT: begin
        if (status.out_free) begin
          if (cfg.comp_enable) begin
            out_r.left_out     <= ol_r;
            out_r.right_out    <= or_r;
            out_r.reduction_db <= env_r[22:0];
          end else begin
            out_r.left_out     <= l_r;
            out_r.right_out    <= r_r;
            out_r.reduction_db <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // The envelope is the block's state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == skpc_pkg::OP_ENV_B) env_r <= env_sum[47:24];
      if (op == skpc_pkg::OP_EMIT && status.out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/soft_knee_peak_compressor.sv */
// ----------------------------------------------------------------------------
// soft_knee_peak_compressor
// Stereo-linked feed-forward peak compressor with a 6 dB soft knee.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one stereo pair per
//   transaction; the result channel (out_valid/out_ready/out_data) returns
//   the compressed pair and the current gain reduction in dB.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; the user
//   must write them only while idle, which the block does not enforce.
// Sequencing:
//   The log2 fraction takes sixteen squaring rounds on the single shared
//   multiplier; a level inside the knee adds the knee steps. A new pair
//   is taken only after the previous result enters the output register.
// Reset:
//   rst_n (synchronous) loads the register defaults and clears the envelope.
// Stall:
//   The result waits in the output register while out_ready is low; a new
//   transaction is still accepted and processed, and it waits before the
//   output stage until the pending result has been taken.
// ----------------------------------------------------------------------------
module soft_knee_peak_compressor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  skpc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output skpc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [skpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  skpc_pkg::cfg_t    cfg;
  skpc_pkg::status_t status;
  skpc_pkg::op_t     op;

  skpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  skpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  skpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The block is busy right after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a pair is in flight");

  // A new result only appears from the emit step.
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(op == skpc_pkg::OP_EMIT))
    else $error("result appeared outside the emit step");

  // Bypass reports no gain reduction.
  a_bypass_no_reduction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cfg.comp_enable) |-> (out_data.reduction_db == '0))
    else $error("reduction reported while disabled");

endmodule

/* verif/soft_knee_peak_compressor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_knee_peak_compressor_tb
// Self-checking bench for the stereo soft-knee peak compressor. A bit-exact
// gain predictor computes the expected stereo pair and gain reduction for each
// accepted transaction. Results are checked in order. The stimulus runs a
// directed phase, then random phases under several register settings, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module soft_knee_peak_compressor_tb;

  // An index that maps to no register; writes to it must be ignored.
  localparam logic [skpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  skpc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  skpc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [skpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [skpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  soft_knee_peak_compressor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's registers and envelope.
  logic signed [9:0] sh_thresh;
  logic [15:0] sh_slope;
  logic [23:0] sh_attack, sh_release;
  logic [7:0] sh_makeup;
  logic sh_enable;
  logic [23:0] sh_env;

  skpc_pkg::in_t pending_pairs[$];
  skpc_pkg::out_t expected_results[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic longint tenths_q16(longint t);
    longint m;
    m = t < 0 ? -t : t;
    m = (m * 65536 + 5) / 10;
    return t < 0 ? -m : m;
  endfunction

  function automatic longint peak_level(longint unsigned peak);
    int e;
    longint unsigned m, frac, neg, mag;
    if (peak == 0) return -longint'(skpc_pkg::FLOOR_DB_Q16);
    e = 0;
    frac = 0;
    while (e < 63 && (peak >> (e + 1)) != 0) e++;
    m = e <= 30 ? peak << (30 - e) : peak >> (e - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    neg = (longint'(skpc_pkg::SAMPLE_BITS - 1) << 16) - ((longint'(e) << 16) + frac);
    mag = (neg * 394566 + 32768) >> 16;
    if (mag > skpc_pkg::FLOOR_DB_Q16) mag = skpc_pkg::FLOOR_DB_Q16;
    return -longint'(mag);
  endfunction

  function automatic longint scale_sample(longint smp, longint unsigned p, longint n);
    longint unsigned mag, lim, r;
    int s;
    mag = smp < 0 ? -smp : smp;
    lim = smp < 0 ? (64'd1 << (skpc_pkg::SAMPLE_BITS - 1))
                  : (64'd1 << (skpc_pkg::SAMPLE_BITS - 1)) - 1;
    s = 16 - n;
    if (s < 1) s = 1;
    if (s > 63) s = 63;
    r = (mag * p + (64'd1 << (s - 1))) >> s;
    if (r > lim) r = lim;
    return smp < 0 ? -longint'(r) : longint'(r);
  endfunction

  // Advances the envelope and returns the expected compressed pair.
  function automatic skpc_pkg::out_t compress_pair(skpc_pkg::in_t x);
    skpc_pkg::out_t o;
    longint l, r, over, d, l2, n, sl, sr;
    longint unsigned al, ar, target, c, env, dm, f, p;
    l = x.left_in;
    r = x.right_in;
    al = l < 0 ? -l : l;
    ar = r < 0 ? -r : r;
    over = peak_level(al > ar ? al : ar) - tenths_q16(sh_thresh);
    if (over <= -skpc_pkg::KNEE_HALF_Q16) target = 0;
    else if (over >= skpc_pkg::KNEE_HALF_Q16) target = (longint'(over) * sh_slope) >> 16;
    else begin
      target = longint'(over + skpc_pkg::KNEE_HALF_Q16);
      target = (sh_slope * target * target) / (64'd12 << 32);
    end
    env = sh_env;
    c = target > env ? sh_attack : sh_release;
    env = (c * env + ((64'd1 << 24) - c) * target + (64'd1 << 23)) >> 24;
    sh_env = env[23:0];
    o.left_out = x.left_in;
    o.right_out = x.right_in;
    o.reduction_db = '0;
    if (sh_enable) begin
      d = tenths_q16(sh_makeup) - longint'(sh_env);
      dm = d < 0 ? -d : d;
      l2 = (dm * 2786635 + (64'd1 << 23)) >> 24;
      if (d < 0) l2 = -l2;
      n = l2 >= 0 ? (l2 >>> 16) : -((-l2 + 65535) >>> 16);
      f = l2 - n * 65536;
      p = (5118 * f) >> 16;
      p = ((p + 14824) * f) >> 16;
      p = ((p + 45594) * f) >> 16;
      p += 65536;
      if (n < -64) n = -64;
      sl = scale_sample(l, p, n);
      sr = scale_sample(r, p, n);
      o.left_out = sl[skpc_pkg::SAMPLE_BITS-1:0];
      o.right_out = sr[skpc_pkg::SAMPLE_BITS-1:0];
      o.reduction_db = sh_env[22:0];
    end
    return o;
  endfunction

  // Driver: presents queued pairs, with random idle bursts between them.
  // Acceptances are counted at the rising edge and picked up here.
  int in_gap = 0;
  int n_accepted = 0;
  int n_seen = 0;
  always @(negedge clk) begin
    bit hold;
    hold = in_valid && (n_accepted == n_seen);
    if (rst_n) begin
      if (n_accepted != n_seen) begin
        n_seen = n_accepted;
        if (!quiet && $urandom_range(3) == 0) in_gap = $urandom_range(12, 1);
      end
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_pairs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict at acceptance so the envelope follows the transaction order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results = {expected_results, compress_pair(in_data)};
      void'(pending_pairs.pop_front());
      n_accepted++;
    end
  end

  int out_stall = 0;
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      out_stall <= $urandom_range(12, 1) - 1;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // Monitor.
  always @(posedge clk) begin
    skpc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.left_out !== out_data.left_out) begin
          errors++;
          $display("%0t: left_out expected %0d actual %0d", $realtime,
                   want.left_out, out_data.left_out);
        end
        if (want.right_out !== out_data.right_out) begin
          errors++;
          $display("%0t: right_out expected %0d actual %0d", $realtime,
                   want.right_out, out_data.right_out);
        end
        if (want.reduction_db !== out_data.reduction_db) begin
          errors++;
          $display("%0t: reduction_db expected %0d actual %0d", $realtime,
                   want.reduction_db, out_data.reduction_db);
        end
      end
    end
  end

  task automatic write_reg(logic [skpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [skpc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      skpc_pkg::CFG_THRESHOLD: sh_thresh = val[9:0];
      skpc_pkg::CFG_SLOPE: sh_slope = val[15:0];
      skpc_pkg::CFG_ATTACK: sh_attack = val;
      skpc_pkg::CFG_RELEASE: sh_release = val;
      skpc_pkg::CFG_MAKEUP: sh_makeup = val[7:0];
      skpc_pkg::CFG_ENABLE: sh_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_pair(logic [23:0] l, logic [23:0] r);
    skpc_pkg::in_t x;
    x.left_in = l;
    x.right_in = r;
    pending_pairs = {pending_pairs, x};
  endtask

  // Mostly musical-looking amplitudes, with full-range values mixed in.
  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    int k;
    k = $urandom_range(9);
    v = $urandom;
    if (k < 6) v = $signed(v) >>> $urandom_range(23);
    else if (k == 6) v = {1'b1, 23'd0};
    return v;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) queue_pair(rand_sample(), rand_sample());
  endtask

  initial begin
    sh_thresh = -180;
    sh_slope = 16'd49152;
    sh_attack = 24'd16742300;
    sh_release = 24'd16773721;
    sh_makeup = 8'd30;
    sh_enable = 1'b1;
    sh_env = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: silence, full scale both signs, knee region, disabled pass.
    queue_pair(24'd0, 24'd0);
    queue_pair(24'h800000, 24'd0);
    queue_pair(24'h7FFFFF, 24'h800000);
    queue_pair(24'd1, 24'hFFFFFF);
    queue_pair(24'd0, 24'h7FFFFF);
    queue_pair(24'd940000, 24'd1000000);
    queue_pair(24'd1200000, -24'd1300000);
    queue_pair(24'd1500000, 24'd0);
    queue_pair(24'h555555, 24'hAAAAAA);
    queue_pair(24'hAAAAAA, 24'h555555);
    drain();
    // Fast envelope and large makeup drive the outputs into saturation.
    write_reg(skpc_pkg::CFG_ATTACK, 24'd0);
    write_reg(skpc_pkg::CFG_RELEASE, 24'd0);
    write_reg(skpc_pkg::CFG_MAKEUP, 24'd255);
    write_reg(skpc_pkg::CFG_THRESHOLD, 24'h3FF);
    write_reg(CFG_UNUSED_IDX, 24'h123456);
    queue_pair(24'h7FFFFF, 24'h800000);
    queue_pair(24'd4000000, -24'd4000000);
    queue_pair(24'd100, 24'd0);
    drain();
    write_reg(skpc_pkg::CFG_ENABLE, 24'd0);
    queue_pair(24'h7FFFFF, 24'h800000);
    queue_pair(24'd12345, -24'd54321);
    drain();

    write_reg(skpc_pkg::CFG_ENABLE, 24'd1);
    write_reg(skpc_pkg::CFG_THRESHOLD, -24'd480);
    write_reg(skpc_pkg::CFG_SLOPE, 24'd62915);
    write_reg(skpc_pkg::CFG_ATTACK, 24'd8000000);
    write_reg(skpc_pkg::CFG_RELEASE, 24'd16000000);
    write_reg(skpc_pkg::CFG_MAKEUP, 24'd240);
    random_run(300);
    drain();

    write_reg(skpc_pkg::CFG_THRESHOLD, 24'd0);
    write_reg(skpc_pkg::CFG_SLOPE, 24'd0);
    write_reg(skpc_pkg::CFG_ATTACK, 24'hFFFFFF);
    write_reg(skpc_pkg::CFG_RELEASE, 24'hFFFFFF);
    write_reg(skpc_pkg::CFG_MAKEUP, 24'd0);
    random_run(250);
    drain();

    write_reg(skpc_pkg::CFG_THRESHOLD, 24'h1FF);
    write_reg(skpc_pkg::CFG_SLOPE, 24'hFFFF);
    write_reg(skpc_pkg::CFG_ATTACK, 24'd1000);
    write_reg(skpc_pkg::CFG_RELEASE, 24'd2000000);
    write_reg(skpc_pkg::CFG_MAKEUP, 24'd120);
    random_run(250);
    drain();

    write_reg(skpc_pkg::CFG_ENABLE, 24'd0);
    random_run(150);
    drain();

    write_reg(skpc_pkg::CFG_ENABLE, 24'd1);
    write_reg(skpc_pkg::CFG_THRESHOLD, -24'd180);
    write_reg(skpc_pkg::CFG_SLOPE, 24'd49152);
    write_reg(skpc_pkg::CFG_ATTACK, 24'd16742300);
    write_reg(skpc_pkg::CFG_RELEASE, 24'd16773721);
    write_reg(skpc_pkg::CFG_MAKEUP, 24'd30);
    random_run(400);
    drain();

    // Final stretch without idling on either side.
    quiet = 1'b1;
    random_run(280);
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
